[sv/sha_pkg.sv]
package sha_pkg;

    typedef logic [31:0] word_t;

    // control for the working variable bank
    typedef struct packed {
        logic shift_load;   // shift towards a, new word into h
        logic do_round;     // one compression round
        logic rotate;       // rotate a..h by one place
    } wv_ctrl_t;

    localparam logic [7:0] PAD_MARKER = 8'h80;

    function automatic word_t rotr(word_t x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t bsig0(word_t x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t bsig1(word_t x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t ssig0(word_t x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t ssig1(word_t x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t ch(word_t x, word_t y, word_t z);
        return (x & y) ^ (~x & z);
    endfunction

    function automatic word_t maj(word_t x, word_t y, word_t z);
        return (x & y) ^ (x & z) ^ (y & z);
    endfunction

    // big-endian byte insert; slot 0 starts a fresh word
    function automatic word_t put_byte(word_t acc, logic [1:0] slot, logic [7:0] b);
        word_t base;
        base = (slot == 2'd0) ? '0 : acc;
        case (slot)
            2'd0: base[31:24] = b;
            2'd1: base[23:16] = b;
            2'd2: base[15:8]  = b;
            default: base[7:0] = b;
        endcase
        return base;
    endfunction

    function automatic word_t init_hash(logic [2:0] i);
        word_t r;
        case (i)
            3'd0: r = 32'h6a09e667;
            3'd1: r = 32'hbb67ae85;
            3'd2: r = 32'h3c6ef372;
            3'd3: r = 32'ha54ff53a;
            3'd4: r = 32'h510e527f;
            3'd5: r = 32'h9b05688c;
            3'd6: r = 32'h1f83d9ab;
            default: r = 32'h5be0cd19;
        endcase
        return r;
    endfunction

    function automatic word_t round_k(logic [5:0] t);
        word_t r;
        case (t)
            6'd0:  r = 32'h428a2f98;  6'd1:  r = 32'h71374491;
            6'd2:  r = 32'hb5c0fbcf;  6'd3:  r = 32'he9b5dba5;
            6'd4:  r = 32'h3956c25b;  6'd5:  r = 32'h59f111f1;
            6'd6:  r = 32'h923f82a4;  6'd7:  r = 32'hab1c5ed5;
            6'd8:  r = 32'hd807aa98;  6'd9:  r = 32'h12835b01;
            6'd10: r = 32'h243185be;  6'd11: r = 32'h550c7dc3;
            6'd12: r = 32'h72be5d74;  6'd13: r = 32'h80deb1fe;
            6'd14: r = 32'h9bdc06a7;  6'd15: r = 32'hc19bf174;
            6'd16: r = 32'he49b69c1;  6'd17: r = 32'hefbe4786;
            6'd18: r = 32'h0fc19dc6;  6'd19: r = 32'h240ca1cc;
            6'd20: r = 32'h2de92c6f;  6'd21: r = 32'h4a7484aa;
            6'd22: r = 32'h5cb0a9dc;  6'd23: r = 32'h76f988da;
            6'd24: r = 32'h983e5152;  6'd25: r = 32'ha831c66d;
            6'd26: r = 32'hb00327c8;  6'd27: r = 32'hbf597fc7;
            6'd28: r = 32'hc6e00bf3;  6'd29: r = 32'hd5a79147;
            6'd30: r = 32'h06ca6351;  6'd31: r = 32'h14292967;
            6'd32: r = 32'h27b70a85;  6'd33: r = 32'h2e1b2138;
            6'd34: r = 32'h4d2c6dfc;  6'd35: r = 32'h53380d13;
            6'd36: r = 32'h650a7354;  6'd37: r = 32'h766a0abb;
            6'd38: r = 32'h81c2c92e;  6'd39: r = 32'h92722c85;
            6'd40: r = 32'ha2bfe8a1;  6'd41: r = 32'ha81a664b;
            6'd42: r = 32'hc24b8b70;  6'd43: r = 32'hc76c51a3;
            6'd44: r = 32'hd192e819;  6'd45: r = 32'hd6990624;
            6'd46: r = 32'hf40e3585;  6'd47: r = 32'h106aa070;
            6'd48: r = 32'h19a4c116;  6'd49: r = 32'h1e376c08;
            6'd50: r = 32'h2748774c;  6'd51: r = 32'h34b0bcb5;
            6'd52: r = 32'h391c0cb3;  6'd53: r = 32'h4ed8aa4a;
            6'd54: r = 32'h5b9cca4f;  6'd55: r = 32'h682e6ff3;
            6'd56: r = 32'h748f82ee;  6'd57: r = 32'h78a5636f;
            6'd58: r = 32'h84c87814;  6'd59: r = 32'h8cc70208;
            6'd60: r = 32'h90befffa;  6'd61: r = 32'ha4506ceb;
            6'd62: r = 32'hbef9a3f7;  default: r = 32'hc67178f2;
        endcase
        return r;
    endfunction

endpackage

[sv/sha_ram.sv]
module sha_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

[sv/sha_wvars.sv]
module sha_wvars (
    input  logic              clk,
    input  sha_pkg::wv_ctrl_t ctrl,
    input  sha_pkg::word_t    shift_in,
    input  sha_pkg::word_t    round_w,
    input  logic [5:0]        round_t,
    output sha_pkg::word_t    head
);
    import sha_pkg::*;

    // v_reg[0] is a, v_reg[7] is h
    word_t v_reg [8];
    word_t t1;
    word_t t2;

    always_comb
    begin
        t1 = v_reg[7] + bsig1(v_reg[4]) + ch(v_reg[4], v_reg[5], v_reg[6])
             + round_k(round_t) + round_w;
        t2 = bsig0(v_reg[0]) + maj(v_reg[0], v_reg[1], v_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.do_round)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
        else if (ctrl.shift_load || ctrl.rotate)
        begin
            for (int i = 0; i < 7; i++)
            begin
                v_reg[i] <= v_reg[i + 1];
            end
            v_reg[7] <= ctrl.rotate ? v_reg[0] : shift_in;
        end
    end

    assign head = v_reg[0];

endmodule

[sv/sha256_message_hasher.sv]
// SHA-256 over a byte stream. Each input word carries one byte (tdata), a byte-present
// flag (tuser) and an end-of-message flag (tlast); an end word makes the block pad the
// message, append the 64-bit bit length and send the eight digest words, most significant
// first, with tuser as the word index and tlast on the eighth. Bytes go in one per cycle
// until a 64-byte block is full; the block is then compressed with input held off: it
// loads a..h from the chaining memory, runs 64 rounds (two reads of the dual-port schedule
// memory, expansion, round) and folds a..h back into the chaining memory.
// An end word adds padding writes to the schedule memory ahead of the last compression,
// plus a second padding pass and a further compression when fewer than 9 byte slots are
// left for the length. The fold of the last compression hands out the digest words in
// turn while the output keeps up, and stalls while a word waits to be taken.
// After the digest the hasher starts over from the standard initial value.
module sha256_message_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tuser,   // byte_present
    input  logic        s_axis_tlast,   // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // digest_word
    output logic [2:0]  m_axis_tuser,   // word_index
    output logic        m_axis_tlast    // last_word
);
    import sha_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_PAD     = 9'b000000010,
        S_LOAD    = 9'b000000100,
        S_RND0    = 9'b000001000,
        S_RND1    = 9'b000010000,
        S_RND2    = 9'b000100000,
        S_RND3    = 9'b001000000,
        S_FIN_RD  = 9'b010000000,
        S_FIN_ADD = 9'b100000000
    } state_t;

    state_t      state_reg, state_next;
    logic [5:0]  pos_reg, pos_next;
    word_t       acc_reg, acc_next;
    logic [63:0] bitcnt_reg, bitcnt_next;
    logic [5:0]  round_reg, round_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [3:0]  pad_word_reg, pad_word_next;
    logic        pad_first_reg, pad_first_next;
    logic        pad_len_reg, pad_len_next;
    logic        end_pend_reg, end_pend_next;
    logic        final_reg, final_next;
    logic [7:0]  cv_valid_reg, cv_valid_next;
    logic        cv_vld_q_reg;
    logic [2:0]  cv_addr_q_reg;
    word_t       x2_reg, x2_next;
    word_t       x7_reg, x7_next;
    word_t       w_reg, w_next;
    logic        out_valid_reg, out_valid_next;
    word_t       out_data_reg;
    logic [2:0]  out_index_reg;
    logic        out_last_reg;

    logic        in_acc;
    logic        out_load;
    word_t       sum;
    word_t       cv_word;
    word_t       cv_rdata;
    logic        cv_we;
    logic [2:0]  cv_addr;

    logic        sched_we;
    logic [3:0]  sched_waddr;
    word_t       sched_wdata;
    logic [3:0]  sched_ra;
    logic [3:0]  sched_rb;
    word_t       sched_da;
    word_t       sched_db;

    wv_ctrl_t    wv_ctrl;
    word_t       wv_head;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign cv_addr       = cnt_reg[2:0];
    assign cv_word       = cv_vld_q_reg ? cv_rdata : init_hash(cv_addr_q_reg);
    assign sum           = cv_word + wv_head;

    assign sched_ra = (state_reg == S_RND1) ? round_reg[3:0] - 4'd15 : round_reg[3:0] - 4'd2;
    assign sched_rb = (state_reg == S_RND1) ? round_reg[3:0] : round_reg[3:0] - 4'd7;

    sha_ram #(.WIDTH(32), .DEPTH(16)) u_sched_ram (
        .clk       (clk),
        .we        (sched_we),
        .wr_addr   (sched_waddr),
        .wr_data   (sched_wdata),
        .rd_addr_a (sched_ra),
        .rd_addr_b (sched_rb),
        .rd_data_a (sched_da),
        .rd_data_b (sched_db)
    );

    sha_ram #(.WIDTH(32), .DEPTH(8)) u_chain_ram (
        .clk       (clk),
        .we        (cv_we),
        .wr_addr   (cv_addr),
        .wr_data   (sum),
        .rd_addr_a (cv_addr),
        .rd_addr_b (cv_addr),
        .rd_data_a (cv_rdata),
        .rd_data_b ()
    );

    sha_wvars u_wvars (
        .clk      (clk),
        .ctrl     (wv_ctrl),
        .shift_in (cv_word),
        .round_w  (w_reg),
        .round_t  (round_reg),
        .head     (wv_head)
    );

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        acc_next       = acc_reg;
        bitcnt_next    = bitcnt_reg;
        round_next     = round_reg;
        cnt_next       = cnt_reg;
        pad_word_next  = pad_word_reg;
        pad_first_next = pad_first_reg;
        pad_len_next   = pad_len_reg;
        end_pend_next  = end_pend_reg;
        final_next     = final_reg;
        cv_valid_next  = cv_valid_reg;
        x2_next        = x2_reg;
        x7_next        = x7_reg;
        w_next         = w_reg;
        out_load       = 1'b0;
        cv_we          = 1'b0;
        sched_we       = 1'b0;
        sched_waddr    = pos_reg[5:2];
        sched_wdata    = acc_next;
        wv_ctrl        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (s_axis_tuser)
                    begin
                        acc_next    = put_byte(acc_reg, pos_reg[1:0], s_axis_tdata);
                        bitcnt_next = bitcnt_reg + 64'd8;
                        pos_next    = pos_reg + 6'd1;
                        sched_we    = (pos_reg[1:0] == 2'd3);
                        sched_wdata = acc_next;
                    end
                    if (s_axis_tuser && pos_reg == 6'd63)
                    begin
                        // block full: compress now, pad afterwards if this ends it
                        state_next     = S_LOAD;
                        cnt_next       = 4'd0;
                        final_next     = 1'b0;
                        end_pend_next  = s_axis_tlast;
                        pad_word_next  = 4'd0;
                        pad_first_next = 1'b1;
                        pad_len_next   = 1'b1;
                    end
                    else if (s_axis_tlast)
                    begin
                        state_next     = S_PAD;
                        end_pend_next  = 1'b1;
                        pad_word_next  = pos_next[5:2];
                        pad_first_next = 1'b1;
                        pad_len_next   = (pos_next < 6'd56);
                    end
                end
            end
            S_PAD:
            begin
                sched_we    = 1'b1;
                sched_waddr = pad_word_reg;
                if (pad_first_reg)
                begin
                    sched_wdata = put_byte(acc_reg, pos_reg[1:0], PAD_MARKER);
                end
                else if (pad_len_reg && pad_word_reg == 4'd14)
                begin
                    sched_wdata = bitcnt_reg[63:32];
                end
                else if (pad_len_reg && pad_word_reg == 4'd15)
                begin
                    sched_wdata = bitcnt_reg[31:0];
                end
                else
                begin
                    sched_wdata = '0;
                end
                pad_first_next = 1'b0;
                if (pad_word_reg == 4'd15)
                begin
                    state_next = S_LOAD;
                    cnt_next   = 4'd0;
                    final_next = pad_len_reg;
                    // no room for the length: a second block follows
                    pad_word_next = 4'd0;
                    pad_len_next  = 1'b1;
                end
                else
                begin
                    pad_word_next = pad_word_reg + 4'd1;
                end
            end
            S_LOAD:
            begin
                wv_ctrl.shift_load = (cnt_reg != 4'd0);
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd8)
                begin
                    state_next = S_RND0;
                    round_next = 6'd0;
                    cnt_next   = 4'd0;
                end
            end
            S_RND0:
            begin
                state_next = S_RND1;
            end
            S_RND1:
            begin
                x2_next    = sched_da;
                x7_next    = sched_db;
                state_next = S_RND2;
            end
            S_RND2:
            begin
                if (round_reg < 6'd16)
                begin
                    w_next = sched_db;
                end
                else
                begin
                    w_next      = ssig1(x2_reg) + x7_reg + ssig0(sched_da) + sched_db;
                    sched_we    = 1'b1;
                    sched_waddr = round_reg[3:0];
                    sched_wdata = w_next;
                end
                state_next = S_RND3;
            end
            S_RND3:
            begin
                wv_ctrl.do_round = 1'b1;
                if (round_reg == 6'd63)
                begin
                    state_next = S_FIN_RD;
                    cnt_next   = 4'd0;
                end
                else
                begin
                    round_next = round_reg + 6'd1;
                    state_next = S_RND0;
                end
            end
            S_FIN_RD:
            begin
                // digest words wait for a free output slot
                if (!final_reg || !out_valid_reg || m_axis_tready)
                begin
                    state_next = S_FIN_ADD;
                end
            end
            S_FIN_ADD:
            begin
                wv_ctrl.rotate = 1'b1;
                if (final_reg)
                begin
                    out_load = 1'b1;
                end
                else
                begin
                    cv_we = 1'b1;
                    cv_valid_next[cv_addr] = 1'b1;
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd7)
                begin
                    cnt_next = 4'd0;
                    if (final_reg)
                    begin
                        state_next    = S_IDLE;
                        cv_valid_next = '0;
                        bitcnt_next   = '0;
                        pos_next      = '0;
                        end_pend_next = 1'b0;
                        final_next    = 1'b0;
                    end
                    else if (end_pend_reg)
                    begin
                        state_next = S_PAD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_FIN_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            bitcnt_reg    <= '0;
            round_reg     <= '0;
            cnt_reg       <= '0;
            pad_word_reg  <= '0;
            pad_first_reg <= 1'b0;
            pad_len_reg   <= 1'b0;
            end_pend_reg  <= 1'b0;
            final_reg     <= 1'b0;
            cv_valid_reg  <= '0;
            cv_vld_q_reg  <= 1'b0;
            cv_addr_q_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            bitcnt_reg    <= bitcnt_next;
            round_reg     <= round_next;
            cnt_reg       <= cnt_next;
            pad_word_reg  <= pad_word_next;
            pad_first_reg <= pad_first_next;
            pad_len_reg   <= pad_len_next;
            end_pend_reg  <= end_pend_next;
            final_reg     <= final_next;
            cv_valid_reg  <= cv_valid_next;
            // valid bit travels with the registered chaining read
            cv_vld_q_reg  <= cv_valid_reg[cv_addr];
            cv_addr_q_reg <= cv_addr;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        x2_reg  <= x2_next;
        x7_reg  <= x7_next;
        w_reg   <= w_next;
        if (out_load)
        begin
            out_data_reg  <= sum;
            out_index_reg <= cv_addr;
            out_last_reg  <= (cv_addr == 3'd7);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_index_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef ASSERT_OFF
    a_out_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> !out_valid_reg)
        else $error("digest word loaded over a pending word");

    a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RND3 && round_reg == 6'd63) |=> (state_reg == S_FIN_RD))
        else $error("compression did not close after round 63");

    a_expand_write: assert property (@(posedge clk) disable iff (!rst_n)
        (sched_we && state_reg == S_RND2) |-> (round_reg >= 6'd16))
        else $error("schedule written during a message round");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == 3'd7))
        else $error("last digest word with wrong index");
`endif

endmodule

[tb/sv/sha256_digest_checker.sv]
`timescale 1ns / 1ps
module sha256_digest_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tuser,   // byte_present
    input  logic        s_axis_tlast,   // end_of_message
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // digest_word
    input  logic [2:0]  m_axis_tuser,   // word_index
    input  logic        m_axis_tlast,   // last_word
    output int          mismatch_count,
    output int          digest_words_due
);

    localparam logic [7:0] END_MARKER = 8'h80;
    localparam int PRINT_CAP = 100;

    localparam logic [0:7][31:0] HASH_IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [0:63][31:0] ROUND_CONST = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_entry_t;

    digest_entry_t digest_q[$];
    logic [31:0]   chain_value [8];
    logic [31:0]   msg_block [16];
    logic [63:0]   bit_length;
    logic [5:0]    fill_slot;
    int            errors = 0;
    int            words_pending = 0;

    assign mismatch_count   = errors;
    assign digest_words_due = words_pending;

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        logic [63:0] dbl;
        dbl = {x, x} >> n;
        return dbl[31:0];
    endfunction

    task automatic report_mismatch(input string note);
        errors++;
        if (errors <= PRINT_CAP)
            $display("%0t ns digest mismatch: %s", $time, note);
    endtask

    task automatic restart_message();
        for (int i = 0; i < 8; i++)
            chain_value[i] = HASH_IV[i];
        for (int i = 0; i < 16; i++)
            msg_block[i] = '0;
        bit_length = '0;
        fill_slot  = '0;
    endtask

    // big-endian: slot 0 lands in bits 31:24 of word 0
    task automatic place_byte(input logic [5:0] pos, input logic [7:0] b);
        msg_block[pos[5:2]][{~pos[1:0], 3'b000} +: 8] = b;
    endtask

    task automatic fold_block();
        logic [31:0] sched [64];
        logic [31:0] a, b, c, d, e, f, g, h;
        logic [31:0] t1, t2, s0, s1;
        for (int t = 0; t < 16; t++)
            sched[t] = msg_block[t];
        for (int t = 16; t < 64; t++)
        begin
            s0 = ror(sched[t-15], 7) ^ ror(sched[t-15], 18) ^ (sched[t-15] >> 3);
            s1 = ror(sched[t-2], 17) ^ ror(sched[t-2], 19) ^ (sched[t-2] >> 10);
            sched[t] = s1 + sched[t-7] + s0 + sched[t-16];
        end
        a = chain_value[0]; b = chain_value[1]; c = chain_value[2]; d = chain_value[3];
        e = chain_value[4]; f = chain_value[5]; g = chain_value[6]; h = chain_value[7];
        for (int t = 0; t < 64; t++)
        begin
            t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
                 + ROUND_CONST[t] + sched[t];
            t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain_value[0] += a; chain_value[1] += b; chain_value[2] += c; chain_value[3] += d;
        chain_value[4] += e; chain_value[5] += f; chain_value[6] += g; chain_value[7] += h;
        for (int i = 0; i < 16; i++)
            msg_block[i] = '0;
    endtask

    task automatic absorb_word(input logic [7:0] b, input logic present, input logic last);
        logic [5:0]    pos;
        digest_entry_t entry;
        if (present)
        begin
            place_byte(fill_slot, b);
            bit_length += 64'd8;
            fill_slot  += 6'd1;
            if (fill_slot == 6'd0)
                fold_block();
        end
        if (last)
        begin
            pos = fill_slot;
            place_byte(pos, END_MARKER);
            for (int i = pos + 1; i < 64; i++)
                place_byte(i[5:0], 8'h00);
            // no room for the length: it goes into an extra block
            if (pos >= 6'd56)
                fold_block();
            msg_block[14] = bit_length[63:32];
            msg_block[15] = bit_length[31:0];
            fold_block();
            for (int i = 0; i < 8; i++)
            begin
                entry.digest_word = chain_value[i];
                entry.word_index  = i[2:0];
                entry.last_word   = (i == 7);
                digest_q.push_back(entry);
            end
            restart_message();
        end
    endtask

    task automatic check_digest_word();
        digest_entry_t want;
        if (digest_q.size() == 0)
            report_mismatch($sformatf("unexpected word %h index %0d", m_axis_tdata, m_axis_tuser));
        else
        begin
            want = digest_q.pop_front();
            if (m_axis_tdata !== want.digest_word)
                report_mismatch($sformatf("index %0d: word %h, predicted %h",
                                          want.word_index, m_axis_tdata, want.digest_word));
            if (m_axis_tuser !== want.word_index)
                report_mismatch($sformatf("word index %0d, predicted %0d",
                                          m_axis_tuser, want.word_index));
            if (m_axis_tlast !== want.last_word)
                report_mismatch($sformatf("index %0d: last flag %b, predicted %b",
                                          want.word_index, m_axis_tlast, want.last_word));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_message();
            digest_q.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_digest_word();
            if (s_axis_tvalid && s_axis_tready)
                absorb_word(s_axis_tdata, s_axis_tuser, s_axis_tlast);
        end
        words_pending = digest_q.size();
    end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
module testbench;

    // worst case from an end word to the last digest word: padding, two
    // compressions and eight output words
    localparam int DRAIN_CYCLES = 700;
    localparam int IDLE_PCT     = 24;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        s_axis_tuser  = 1'b0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    int fail_count;
    int words_due;
    int items_sent = 0;
    bit steady     = 1'b0;   // no idling on either side while set

    initial
    begin
        forever #5 clk = ~clk;
    end

    sha256_message_hasher u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    sha256_digest_checker u_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_axis_tvalid    (s_axis_tvalid),
        .s_axis_tready    (s_axis_tready),
        .s_axis_tdata     (s_axis_tdata),
        .s_axis_tuser     (s_axis_tuser),
        .s_axis_tlast     (s_axis_tlast),
        .m_axis_tvalid    (m_axis_tvalid),
        .m_axis_tready    (m_axis_tready),
        .m_axis_tdata     (m_axis_tdata),
        .m_axis_tuser     (m_axis_tuser),
        .m_axis_tlast     (m_axis_tlast),
        .mismatch_count   (fail_count),
        .digest_words_due (words_due)
    );

    always @(negedge clk)
        m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);

    initial
    begin
        #(10_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic send_word(input logic [7:0] b, input logic present, input logic last);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= present;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
        if (present || last)
            items_sent++;
    endtask

    // random content; the end flag rides on the last byte or on a word of its own
    task automatic send_message(input int len, input bit end_on_byte);
        for (int k = 0; k < len; k++)
        begin
            if (!steady && $urandom_range(99) < 4)
                send_word(8'($urandom_range(255)), 1'b0, 1'b0);
            send_word(8'($urandom_range(255)), 1'b1, end_on_byte && (k == len - 1));
        end
        if (len == 0 || !end_on_byte)
            send_word(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    task automatic wait_for_digests();
        s_axis_tvalid <= 1'b0;
        while (words_due != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int msg_no;
        int len;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty message, ignored words, then short messages with extreme bytes
        send_word(8'hff, 1'b0, 1'b1);
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'hff, 1'b0, 1'b0);
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h63, 1'b1, 1'b1);
        send_word(8'h00, 1'b1, 1'b1);
        send_word(8'hff, 1'b1, 1'b0);
        send_word(8'h5a, 1'b0, 1'b1);
        send_word(8'hff, 1'b1, 1'b0);
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'h80, 1'b1, 1'b1);
        send_word(8'hff, 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b1);

        wait_for_digests();

        // first few lengths hit the padding boundaries and a full block
        msg_no = 0;
        while (items_sent < 200)
        begin
            steady = (msg_no >= 1 && msg_no <= 2);
            case (msg_no)
                0: len = 55;
                1: len = 56;
                2: len = 64;
                default:
                begin
                    case ($urandom_range(9))
                        6: len = $urandom_range(57, 63);
                        7: len = $urandom_range(64, 70);
                        8: len = $urandom_range(119, 128);
                        default: len = $urandom_range(0, 20);
                    endcase
                end
            endcase
            send_message(len, 1'($urandom_range(1)));
            msg_no++;
        end
        steady = 1'b0;

        wait_for_digests();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
